FILE: rtl/eopp_pkg.sv
// ----------------------------------------------------------------------------
// Escape orbit pixel plotter package
// Shared types and constants for the controller and the datapath modules.
// ----------------------------------------------------------------------------
package eopp_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned LenW    = 7;
  localparam int unsigned IndexW  = 24;
  localparam int unsigned DimW    = 13;
  localparam int unsigned BailW   = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 64;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned OutUserW = 3;

  localparam logic [CfgIdxW-1:0] CFG_BAILOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT  = 2'd2;

  localparam logic [BailW-1:0] BAIL_RESET   = 31'h4000_0000;
  localparam logic [DimW-1:0]  WIDTH_RESET  = 13'd2048;
  localparam logic [DimW-1:0]  HEIGHT_RESET = 13'd1080;

  // Commands from the controller to the orbit datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
  } eopp_cmd_t;

  // One entry handed to the pixel mapping pipeline.
  typedef struct packed {
    logic            vld;
    logic            point;
    logic            escaped;
    logic            last;
    logic [LenW-1:0] len;
  } eopp_issue_t;

endpackage

FILE: rtl/eopp_orbit_dp.sv
// ----------------------------------------------------------------------------
// Orbit datapath
// Holds z and c, squares z with three multipliers, tests the escape radius,
// updates z with saturation and keeps the orbit points in a memory.
// ----------------------------------------------------------------------------
module eopp_orbit_dp #(
  parameter int unsigned ORBIT_LIMIT = 64
) (
  input  logic                                  clk_i,
  input  eopp_pkg::eopp_cmd_t                   cmd_i,
  input  logic [eopp_pkg::CoordW-1:0]           c_real_i,
  input  logic [eopp_pkg::CoordW-1:0]           c_imag_i,
  input  logic [eopp_pkg::BailW-1:0]            bailout_i,
  input  logic [$clog2(ORBIT_LIMIT)-1:0]        wr_addr_i,
  input  logic                                  rd_en_i,
  input  logic [$clog2(ORBIT_LIMIT)-1:0]        rd_addr_i,
  output logic                                  esc_o,
  output logic [2*eopp_pkg::CoordW-1:0]         rd_data_o
);
  import eopp_pkg::*;

  logic signed [31:0] zx_q, zy_q, cx_q, cy_q;
  logic signed [63:0] xx_q, yy_q, xy_q;
  logic [63:0]        mem_q [ORBIT_LIMIT];
  logic [63:0]        rd_data_q;

  logic [BailW-1:0]   bail_c;
  logic [63:0]        mag;
  logic [63:0]        lim;
  logic signed [63:0] dxy;
  logic signed [37:0] nx_w, ny_w;
  logic signed [31:0] nx, ny;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    bail_c = (bailout_i > BAIL_RESET) ? BAIL_RESET : bailout_i;
    lim    = {5'b0, bail_c, 28'b0};
    mag    = $unsigned(xx_q) + $unsigned(yy_q);
    esc_o  = mag > lim;
    dxy    = xx_q - yy_q;
    nx_w   = $signed(dxy[63:28]) + cx_q;
    ny_w   = $signed(xy_q[63:27]) + cy_q;
    nx     = sat32(nx_w);
    ny     = sat32(ny_w);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      zx_q <= $signed(c_real_i);
      zy_q <= $signed(c_imag_i);
      cx_q <= $signed(c_real_i);
      cy_q <= $signed(c_imag_i);
    end else if (cmd_i.upd) begin
      zx_q <= nx;
      zy_q <= ny;
    end
    if (cmd_i.mul) begin
      xx_q <= zx_q * zx_q;
      yy_q <= zy_q * zy_q;
      xy_q <= zx_q * zy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      mem_q[wr_addr_i] <= {ny, nx};
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/eopp_map_dp.sv
// ----------------------------------------------------------------------------
// Pixel mapping datapath
// Stalling pipeline that maps orbit points to pixel and mirrored indexes
// and holds the output word until the sink takes it.
// ----------------------------------------------------------------------------
module eopp_map_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  eopp_pkg::eopp_issue_t               issue_i,
  input  logic [2*eopp_pkg::CoordW-1:0]       rd_data_i,
  input  logic [eopp_pkg::DimW-1:0]           width_i,
  input  logic [eopp_pkg::DimW-1:0]           height_i,
  output logic                                adv_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: pixel_index, mirror_index, escape_length, one zero pad bit.
  output logic [eopp_pkg::OutDataW-1:0]       m_axis_tdata,
  // tuser: escaped, point_valid, in_image.
  output logic [eopp_pkg::OutUserW-1:0]       m_axis_tuser,
  output logic                                m_axis_tlast
);
  import eopp_pkg::*;

  eopp_issue_t s0_q, s1_q, s2_q, out_q;

  logic signed [46:0] pxm_d, pym_d, pxm_q, pym_q;
  logic signed [46:0] pxr, pyr;
  logic signed [16:0] pxt, pyt, wx, hx;
  logic               inside_d, inside_q;
  logic [DimW-1:0]    px_q, py_q, hm_q;
  logic [25:0]        psum, msum;
  logic [IndexW-1:0]  pix_q, mir_q;
  logic               in_img_q;
  logic signed [32:0] ax;
  logic signed [13:0] ws;
  logic signed [46:0] hterm;

  assign adv_o = !out_q.vld || m_axis_tready;

  always_comb begin
    ws    = $signed({1'b0, width_i});
    ax    = $signed({rd_data_i[31], rd_data_i[31:0]}) + 33'sh0_2000_0000;
    hterm = $signed({5'b0, height_i, 29'b0});
    pxm_d = ax * ws;
    pym_d = $signed(rd_data_i[63:32]) * ws + hterm;

    pxr = pxm_q[46] ? pxm_q + 47'sh3FFF_FFFF : pxm_q;
    pyr = pym_q[46] ? pym_q + 47'sh3FFF_FFFF : pym_q;
    pxt = $signed(pxr[46:30]);
    pyt = $signed(pyr[46:30]);
    wx  = $signed({4'b0, width_i});
    hx  = $signed({4'b0, height_i});
    inside_d = !pxt[16] && (pxt < wx) && !pyt[16] && (pyt < hx);

    psum = {13'b0, px_q} + py_q * width_i;
    msum = {13'b0, px_q} + hm_q * width_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q  <= '0;
      s1_q  <= '0;
      s2_q  <= '0;
      out_q <= '0;
    end else if (adv_o) begin
      s0_q  <= issue_i;
      s1_q  <= s0_q;
      s2_q  <= s1_q;
      out_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      pxm_q    <= pxm_d;
      pym_q    <= pym_d;
      inside_q <= s1_q.point && inside_d;
      px_q     <= pxt[12:0];
      py_q     <= pyt[12:0];
      hm_q     <= height_i - pyt[12:0] - 13'd1;
      in_img_q <= inside_q;
      pix_q    <= inside_q ? psum[23:0] : '0;
      mir_q    <= inside_q ? msum[23:0] : '0;
    end
  end

  assign m_axis_tvalid = out_q.vld;
  assign m_axis_tdata  = {1'b0, out_q.len, mir_q, pix_q};
  assign m_axis_tuser  = {in_img_q, out_q.point, out_q.escaped};
  assign m_axis_tlast  = out_q.last;

endmodule

FILE: rtl/eopp_ctrl.sv
// ----------------------------------------------------------------------------
// Controller
// Sequences the load, square and update steps of one orbit and then hands
// the stored points, or one marker, to the mapping pipeline.
// ----------------------------------------------------------------------------
module eopp_ctrl #(
  parameter int unsigned ORBIT_LIMIT = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                esc_i,
  input  logic                                adv_i,
  output eopp_pkg::eopp_cmd_t                 cmd_o,
  output eopp_pkg::eopp_issue_t               issue_o,
  output logic [$clog2(ORBIT_LIMIT)-1:0]      wr_addr_o,
  output logic                                rd_en_o,
  output logic [$clog2(ORBIT_LIMIT)-1:0]      rd_addr_o
);
  import eopp_pkg::*;

  localparam int unsigned AW = $clog2(ORBIT_LIMIT);
  localparam logic [AW-1:0] CntMax = AW'(ORBIT_LIMIT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_EMIT,
    ST_MARK
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d, idx_q, idx_d;
  logic [LenW-1:0] len_q, len_d;
  logic            esc_q, esc_d;
  logic            last_pt;

  assign last_pt = (LenW'(idx_q) == len_q - LenW'(1));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    len_d      = len_q;
    esc_d      = esc_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    issue_o    = '0;
    rd_en_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        if (esc_i) begin
          esc_d   = 1'b1;
          len_d   = LenW'(cnt_q);
          idx_d   = '0;
          state_d = (cnt_q == '0) ? ST_MARK : ST_EMIT;
        end else begin
          cmd_o.upd = 1'b1;
          if (cnt_q == CntMax) begin
            esc_d   = 1'b0;
            len_d   = '0;
            state_d = ST_MARK;
          end else begin
            cnt_d   = cnt_q + AW'(1);
            state_d = ST_MUL;
          end
        end
      end
      ST_EMIT: begin
        issue_o.vld     = 1'b1;
        issue_o.point   = 1'b1;
        issue_o.escaped = 1'b1;
        issue_o.last    = last_pt;
        issue_o.len     = len_q;
        rd_en_o         = adv_i;
        if (adv_i) begin
          idx_d = idx_q + AW'(1);
          if (last_pt) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MARK: begin
        issue_o.vld     = 1'b1;
        issue_o.escaped = esc_q;
        issue_o.last    = 1'b1;
        issue_o.len     = len_q;
        if (adv_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      len_q   <= '0;
      esc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      esc_q   <= esc_d;
    end
  end

  assign wr_addr_o = cnt_q;
  assign rd_addr_o = idx_q;

endmodule

FILE: rtl/escape_orbit_pixel_plotter_top.sv
// ----------------------------------------------------------------------------
// Escape orbit pixel plotter
// Iterates z = z*z + c from a start point and maps each stored orbit point
// of an escaping orbit to a pixel index and its vertical mirror.
// ----------------------------------------------------------------------------
// Each orbit step runs a multiply state, then a test state. An orbit escaping
// after n > 0 steps issues its n stored points, one word per cycle unless the
// output is held; each word passes registers s0, s1, s2 and out. An orbit
// that escapes at once or not within ORBIT_LIMIT steps issues one marker
// word. The next start point is taken once the last word is issued; a held
// output stalls the issue. Reset clears control, valid and config state only.
module escape_orbit_pixel_plotter_top #(
  parameter int unsigned ORBIT_LIMIT = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: c_real, c_imag.
  input  logic [eopp_pkg::InDataW-1:0]         s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: pixel_index, mirror_index, escape_length, one zero pad bit.
  output logic [eopp_pkg::OutDataW-1:0]        m_axis_tdata,
  // tuser: escaped, point_valid, in_image.
  output logic [eopp_pkg::OutUserW-1:0]        m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [eopp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [eopp_pkg::BailW-1:0]           cfg_data_i
);
  import eopp_pkg::*;

  localparam int unsigned AW = $clog2(ORBIT_LIMIT);

  logic [BailW-1:0] bail_q;
  logic [DimW-1:0]  width_q, height_q;

  eopp_cmd_t        cmd;
  eopp_issue_t      issue;
  logic             esc, adv, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [63:0]      rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bail_q   <= BAIL_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BAILOUT: bail_q   <= cfg_data_i;
        CFG_WIDTH:   width_q  <= cfg_data_i[DimW-1:0];
        CFG_HEIGHT:  height_q <= cfg_data_i[DimW-1:0];
        default: begin
        end
      endcase
    end
  end

  eopp_ctrl #(
    .ORBIT_LIMIT(ORBIT_LIMIT)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .esc_i     (esc),
    .adv_i     (adv),
    .cmd_o     (cmd),
    .issue_o   (issue),
    .wr_addr_o (wr_addr),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr)
  );

  eopp_orbit_dp #(
    .ORBIT_LIMIT(ORBIT_LIMIT)
  ) u_orbit (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .c_real_i (s_axis_tdata[31:0]),
    .c_imag_i (s_axis_tdata[63:32]),
    .bailout_i(bail_q),
    .wr_addr_i(wr_addr),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .esc_o    (esc),
    .rd_data_o(rd_data)
  );

  eopp_map_dp u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .rd_data_i    (rd_data),
    .width_i      (width_q),
    .height_i     (height_q),
    .adv_o        (adv),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escape orbit pixel plotter testbench
// Sends start points over the input stream and computes the orbit of each
// one and its pixel words. Every word that leaves the block is checked
// against that prediction. It covers directed extremes, register sweeps,
// random orbits under varying stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import eopp_pkg::*;

  localparam int unsigned ORBIT_LIMIT = 64;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam longint Q28_TWO  = 64'sd536870912;
  localparam longint Q28_FOUR = 64'sd1073741824;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 600;

  typedef struct {
    logic              escaped;
    logic              point_valid;
    logic              in_image;
    logic [IndexW-1:0] pixel_index;
    logic [IndexW-1:0] mirror_index;
    logic [LenW-1:0]   escape_length;
    logic              last;
  } plot_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [BailW-1:0]    cfg_data_i;

  logic [BailW-1:0] bail_cfg;
  logic [DimW-1:0]  width_cfg;
  logic [DimW-1:0]  height_cfg;
  logic [63:0]      orbit_mem [ORBIT_LIMIT];

  plot_word_t expected_words[$];

  int failures;
  int points_sent;
  int words_checked;
  int escaped_runs;
  int marker_runs;
  int longest_orbit;
  int settings_used;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int stall_cycles;

  escape_orbit_pixel_plotter_top #(
    .ORBIT_LIMIT(ORBIT_LIMIT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic predict_orbit(input logic [31:0] cr, input logic [31:0] ci);
    longint cx, cy, zx, zy, xx, yy, xy, w, h, px, py;
    longint unsigned mag, lim;
    logic [BailW-1:0] bail;
    logic esc, in_img;
    int n, k;
    plot_word_t word;
    cx = longint'(signed'(cr));
    cy = longint'(signed'(ci));
    bail = (bail_cfg > BAIL_RESET) ? BAIL_RESET : bail_cfg;
    lim = longint'(bail) << 28;
    w = longint'(width_cfg);
    h = longint'(height_cfg);
    zx = cx;
    zy = cy;
    esc = 1'b0;
    n = 0;
    k = 0;
    while (k < ORBIT_LIMIT && !esc) begin
      xx = zx * zx;
      yy = zy * zy;
      mag = xx + yy;
      if (mag > lim) begin
        esc = 1'b1;
        n = k;
      end else begin
        xy = zx * zy;
        zx = clamp32(((xx - yy) >>> 28) + cx);
        zy = clamp32((xy >>> 27) + cy);
        orbit_mem[k] = {zy[31:0], zx[31:0]};
        k = k + 1;
      end
    end
    if (!esc || n == 0) begin
      word.escaped       = esc;
      word.point_valid   = 1'b0;
      word.in_image      = 1'b0;
      word.pixel_index   = '0;
      word.mirror_index  = '0;
      word.escape_length = n[LenW-1:0];
      word.last          = 1'b1;
      expected_words.push_back(word);
      marker_runs++;
    end else begin
      escaped_runs++;
      if (n > longest_orbit) longest_orbit = n;
      for (k = 0; k < n; k++) begin
        zx = longint'(signed'(orbit_mem[k][31:0]));
        zy = longint'(signed'(orbit_mem[k][63:32]));
        px = ((zx + Q28_TWO) * w) / Q28_FOUR;
        py = (zy * w + h * Q28_TWO) / Q28_FOUR;
        in_img = (px >= 0) && (px < w) && (py >= 0) && (py < h);
        xx = px + py * w;
        yy = px + (h - py - 1) * w;
        word.escaped       = 1'b1;
        word.point_valid   = 1'b1;
        word.in_image      = in_img;
        word.pixel_index   = in_img ? xx[IndexW-1:0] : '0;
        word.mirror_index  = in_img ? yy[IndexW-1:0] : '0;
        word.escape_length = n[LenW-1:0];
        word.last          = (k + 1 == n);
        expected_words.push_back(word);
      end
    end
  endtask

  function automatic void compare_field(input string field, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin
    plot_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("result word with no start point pending: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        failures++;
      end else begin
        want = expected_words.pop_front();
        compare_field("escaped", 64'(want.escaped), 64'(m_axis_tuser[0]));
        compare_field("point_valid", 64'(want.point_valid), 64'(m_axis_tuser[1]));
        compare_field("in_image", 64'(want.in_image), 64'(m_axis_tuser[2]));
        compare_field("pixel_index", 64'(want.pixel_index), 64'(m_axis_tdata[23:0]));
        compare_field("mirror_index", 64'(want.mirror_index), 64'(m_axis_tdata[47:24]));
        compare_field("escape_length", 64'(want.escape_length),
                      64'(m_axis_tdata[54:48]));
        compare_field("last_of_run", 64'(want.last), 64'(m_axis_tlast));
        words_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d words pending",
                 stall_cycles, expected_words.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_point(input logic [31:0] cr, input logic [31:0] ci);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ci, cr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_orbit(cr, ci);
    points_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [BailW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_BAILOUT: bail_cfg = value;
      CFG_WIDTH:   width_cfg = value[DimW-1:0];
      CFG_HEIGHT:  height_cfg = value[DimW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [BailW-1:0] bail, input logic [DimW-1:0] w,
                                input logic [DimW-1:0] h);
    logic [BailW-DimW-1:0] junk;
    wait_drained();
    write_register(CFG_BAILOUT, bail);
    junk = (BailW-DimW)'($urandom);
    write_register(CFG_WIDTH, {junk, w});
    junk = (BailW-DimW)'($urandom);
    write_register(CFG_HEIGHT, {junk, h});
    settings_used++;
  endtask

  task automatic random_point(output logic [31:0] cr, output logic [31:0] ci);
    int pick, re, im;
    pick = $urandom_range(99);
    if (pick < 20) begin
      re = $urandom;
      im = $urandom;
    end else if (pick < 45) begin
      re = 67108864 + int'($urandom_range(16777216));
      im = int'($urandom_range(8388608)) - 4194304;
    end else begin
      re = -536870912 + int'($urandom_range(671088640));
      im = int'($urandom_range(671088640)) - 335544320;
    end
    cr = re;
    ci = im;
  endtask

  task automatic send_random_points(input int count);
    logic [31:0] cr, ci;
    repeat (count) begin
      random_point(cr, ci);
      send_point(cr, ci);
    end
  endtask

  task automatic test_directed_points();
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h8000_0000);
    send_point(-32'sd536870912, 32'h0000_0000);
    send_point(-32'sd536870912, 32'sd26844);
    send_point(32'sd69793218, 32'h0000_0000);
    send_point(32'sd80530637, 32'h0000_0000);
    send_point(32'sd268435456, 32'sd268435456);
    send_point(32'h0000_0000, 32'sd268435456);
    send_point(-32'sd268435456, 32'h0000_0000);
    send_point(32'sd134217728, 32'sd134217728);
    send_point(-32'sd201326592, 32'sd26843546);
    send_point(32'sd536870911, 32'h0000_0000);
    send_point(-32'sd510027366, 32'h0000_0000);
  endtask

  task automatic test_register_sweep();
    apply_settings(31'h7FFF_FFFF, 13'd8191, 13'd8191);
    send_random_points(7);
    apply_settings(31'd0, 13'd0, 13'd0);
    send_random_points(7);
    apply_settings(31'd268435456, 13'd1, 13'd1);
    send_random_points(7);
    wait_drained();
    write_register(CFG_UNUSED, 31'($urandom));
    send_random_points(7);
    apply_settings(31'h4000_0001, 13'd4096, 13'd4096);
    send_random_points(7);
    apply_settings(31'd805306368, 13'd640, 13'd480);
    send_random_points(7);
    apply_settings(BAIL_RESET, 13'd0, HEIGHT_RESET);
    send_random_points(7);
    apply_settings(BAIL_RESET, WIDTH_RESET, 13'd0);
    send_random_points(7);
    apply_settings(BAIL_RESET, WIDTH_RESET, HEIGHT_RESET);
  endtask

  task automatic test_random_orbits(input int count);
    int left, chunk;
    logic [BailW-1:0] bail;
    logic [DimW-1:0] w, h;
    left = count;
    while (left > 0) begin
      case ($urandom_range(3))
        0: begin
          bail = BAIL_RESET;
          w = DimW'($urandom_range(4096, 1));
          h = DimW'($urandom_range(4096, 1));
        end
        1: begin
          bail = BailW'($urandom_range(1073741824));
          w = DimW'($urandom_range(64, 1));
          h = DimW'($urandom_range(64, 1));
        end
        2: begin
          bail = BailW'($urandom);
          w = DimW'($urandom);
          h = DimW'($urandom);
        end
        default: begin
          bail = BAIL_RESET;
          w = WIDTH_RESET;
          h = HEIGHT_RESET;
        end
      endcase
      apply_settings(bail, w, h);
      chunk = (left < 40) ? left : 40;
      send_random_points(chunk);
      left -= chunk;
    end
  endtask

  task automatic test_output_backpressure();
    logic [31:0] ci;
    apply_settings(BAIL_RESET, WIDTH_RESET, HEIGHT_RESET);
    hold_request = HOLD_CYCLES;
    repeat (16) begin
      ci = int'($urandom_range(8388608)) - 4194304;
      send_point(67108864 + int'($urandom_range(8388608)), ci);
    end
    wait_drained();
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_BAILOUT;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    bail_cfg      = BAIL_RESET;
    width_cfg     = WIDTH_RESET;
    height_cfg    = HEIGHT_RESET;
    failures      = 0;
    points_sent   = 0;
    words_checked = 0;
    escaped_runs  = 0;
    marker_runs   = 0;
    longest_orbit = 0;
    settings_used = 0;
    hold_request  = 0;
    stall_cycles  = 0;
    send_idle_pct = 33;
    recv_idle_pct = 54;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_points();
    test_register_sweep();
    send_idle_pct = 54;
    recv_idle_pct = 33;
    test_random_orbits(200);
    test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_orbits(180);
    wait_drained();

    $display("Checked %0d words from %0d start points under %0d register settings.",
             words_checked, points_sent, settings_used);
    $display("Escaping orbits: %0d, marker words: %0d, longest orbit: %0d steps.",
             escaped_runs, marker_runs, longest_orbit);
    if (failures == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: escape_orbit_pixel_plotter_top.f
rtl/eopp_pkg.sv
rtl/eopp_orbit_dp.sv
rtl/eopp_map_dp.sv
rtl/eopp_ctrl.sv
rtl/escape_orbit_pixel_plotter_top.sv
bench/testbench.sv
